// ----- src/assert_macros.svh -----
// Assertion macros shared by the logic instruction unit.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next cycle.
`define MLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mli_pkg.sv -----
// Package of the logic instruction unit: payload structs, decoded item,
// opcode and result codes, and the shared logic operation function.
`default_nettype none

package mli_pkg;

  localparam logic [15:0] SR_IMPL_MASK = 16'hA71F;
  localparam logic [15:0] SR_RESET     = 16'h2700;
  localparam int unsigned SR_S_BIT     = 13;

  localparam logic [15:0] OP_ANDI_CCR = 16'h023C;
  localparam logic [15:0] OP_ANDI_SR  = 16'h027C;
  localparam logic [15:0] OP_ORI_CCR  = 16'h003C;
  localparam logic [15:0] OP_ORI_SR   = 16'h007C;
  localparam logic [15:0] OP_EORI_CCR = 16'h0A3C;
  localparam logic [15:0] OP_EORI_SR  = 16'h0A7C;

  localparam logic [15:0] OP_HI_MASK  = 16'hFF00;
  localparam logic [15:0] OP_ORI      = 16'h0000;
  localparam logic [15:0] OP_ANDI     = 16'h0200;
  localparam logic [15:0] OP_EORI     = 16'h0A00;
  localparam logic [15:0] OP_NOT      = 16'h4600;
  localparam logic [15:0] OP_EOR_MASK = 16'hF100;
  localparam logic [15:0] OP_EOR      = 16'hB100;
  localparam logic [15:0] OP_LINE_MASK = 16'hF000;
  localparam logic [15:0] OP_AND      = 16'hC000;
  localparam logic [15:0] OP_OR       = 16'h8000;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_DREG = 2'd1;
  localparam logic [1:0] TGT_EA   = 2'd2;

  localparam logic [1:0] OPSZ_BYTE = 2'd0;
  localparam logic [1:0] OPSZ_WORD = 2'd1;
  localparam logic [1:0] OPSZ_LONG = 2'd2;
  localparam logic [1:0] OPSZ_BAD  = 2'd3;

  localparam logic [1:0] OUTCOME_EXEC    = 2'd0;
  localparam logic [1:0] OUTCOME_PRIV    = 2'd1;
  localparam logic [1:0] OUTCOME_ILLEGAL = 2'd2;

  localparam logic [2:0] MODE_DREG = 3'd0;
  localparam logic [2:0] MODE_AREG = 3'd1;
  localparam logic [2:0] MODE_EXT  = 3'd7;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_LOGIC,
    CLS_CCR,
    CLS_SR
  } op_class_e;

  typedef enum logic [1:0] {
    LK_AND,
    LK_OR,
    LK_EOR
  } logic_kind_e;

  typedef struct packed {
    logic [15:0] opcode;
    logic [31:0] immediate;
    logic [31:0] dreg_operand;
    logic [31:0] ea_operand;
    logic [4:0]  ea_extra_cycles;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  write_target;
    logic [2:0]  target_reg;
    logic [1:0]  op_size;
    logic [15:0] status_out;
    logic [1:0]  outcome;
    logic        leave_supervisor;
    logic [5:0]  cycle_count;
  } out_item_t;

  // Classified instruction as it waits between decode and execute.
  typedef struct packed {
    op_class_e   cls;
    logic_kind_e kind;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [1:0]  size;
    logic [1:0]  tgt;
    logic [2:0]  treg;
    logic [5:0]  cyc;
  } dec_item_t;

  function automatic logic [31:0] logic_apply(logic_kind_e kind, logic [31:0] a,
                                              logic [31:0] b);
    logic [31:0] r;
    case (kind)
      LK_AND:  r = a & b;
      LK_OR:   r = a | b;
      default: r = a ^ b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/m68k_logic_instruction_unit.sv -----
// Top level of the logic instruction unit: decode front, decoded-item queue
// and execute back. Uses mli_pkg, mli_front, mli_queue and mli_back.
//
// Usage:
//   Input channel: drive item_i and raise push; the instruction transfers at a
//   rising edge where push is high and full is low. Each item carries one
//   opcode with its immediate, data-register and effective-address operands.
//   Result channel: while empty is low, result_o holds the oldest result; it
//   transfers at a rising edge where pop is high and empty is low.
//   Path: the decoded item is written into the queue at the input transfer;
//   the execute stage registers it into result_o once the result slot is free
//   or being popped, and it can be popped from then on.
//   Throughput: one instruction per cycle, sustained while pop stays high; the single
//   status register update in the execute stage sets this figure.
//   Stalls: when pop stays low, the result register holds, the two-entry queue
//   fills, and full rises once two more decoded items are waiting.
//   Reset: asynchronous, active low; the queue and result register empty and
//   the status register returns to 0x2700 (supervisor, interrupts masked).
`default_nettype none

module m68k_logic_instruction_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  mli_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output mli_pkg::out_item_t result_o
);
  import mli_pkg::*;

  dec_item_t dec_in;
  dec_item_t dec_out;
  logic      dec_valid;
  logic      dec_take;

  mli_front u_front (
    .item_i (item_i),
    .dec_o  (dec_in)
  );

  mli_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (push),
    .wr_data_i (dec_in),
    .full_o    (full),
    .rd_i      (dec_take),
    .valid_o   (dec_valid),
    .rd_data_o (dec_out)
  );

  mli_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (dec_valid),
    .dec_i       (dec_out),
    .dec_take_o  (dec_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

// ----- src/mli_front.sv -----
// Decode front of the logic instruction unit: classifies one opcode,
// selects operands and works out the write target and cycle count. Uses mli_pkg.
`default_nettype none

module mli_front (
  input  mli_pkg::in_item_t  item_i,
  output mli_pkg::dec_item_t dec_o
);
  import mli_pkg::*;

  logic [15:0] op;
  logic [2:0]  mode;
  logic [2:0]  ereg;
  logic [1:0]  sz;
  logic [2:0]  opm;
  logic        data_alt;
  logic        mem_alt;
  logic        data_src;
  logic        dreg_dst;
  logic        is_long;
  logic [5:0]  extra;

  assign op       = item_i.opcode;
  assign mode     = op[5:3];
  assign ereg     = op[2:0];
  assign sz       = op[7:6];
  assign opm      = op[8:6];
  assign extra    = {1'b0, item_i.ea_extra_cycles};
  assign dreg_dst = (mode == MODE_DREG);
  assign is_long  = (sz == OPSZ_LONG);

  assign data_alt = (mode != MODE_AREG) && ((mode != MODE_EXT) || (ereg <= 3'd1));
  assign mem_alt  = (mode != MODE_DREG) && (mode != MODE_AREG) &&
                    ((mode != MODE_EXT) || (ereg <= 3'd1));
  assign data_src = (mode != MODE_AREG) && ((mode != MODE_EXT) || (ereg <= 3'd4));

  always_comb begin
    dec_o      = '0;
    dec_o.cls  = CLS_NONE;
    dec_o.kind = LK_AND;
    if (op == OP_ANDI_CCR || op == OP_ORI_CCR || op == OP_EORI_CCR) begin
      dec_o.cls  = CLS_CCR;
      dec_o.kind = (op == OP_ANDI_CCR) ? LK_AND : (op == OP_ORI_CCR) ? LK_OR : LK_EOR;
      // AND to the condition codes must leave the system byte untouched.
      dec_o.opb  = {16'h0000, (op == OP_ANDI_CCR) ? 8'hFF : 8'h00, item_i.immediate[7:0]};
      dec_o.size = OPSZ_BYTE;
      dec_o.cyc  = 6'd20;
    end else if (op == OP_ANDI_SR || op == OP_ORI_SR || op == OP_EORI_SR) begin
      dec_o.cls  = CLS_SR;
      dec_o.kind = (op == OP_ANDI_SR) ? LK_AND : (op == OP_ORI_SR) ? LK_OR : LK_EOR;
      dec_o.opb  = {16'h0000, item_i.immediate[15:0]};
      dec_o.size = OPSZ_WORD;
    end else if (((op & OP_HI_MASK) == OP_ORI || (op & OP_HI_MASK) == OP_ANDI ||
                  (op & OP_HI_MASK) == OP_EORI) && sz != OPSZ_BAD && data_alt) begin
      dec_o.cls  = CLS_LOGIC;
      dec_o.kind = ((op & OP_HI_MASK) == OP_ANDI) ? LK_AND :
                   ((op & OP_HI_MASK) == OP_ORI) ? LK_OR : LK_EOR;
      dec_o.opa  = item_i.immediate;
      dec_o.opb  = item_i.ea_operand;
      dec_o.size = sz;
      dec_o.tgt  = dreg_dst ? TGT_DREG : TGT_EA;
      dec_o.treg = dreg_dst ? ereg : 3'd0;
      dec_o.cyc  = dreg_dst ? (is_long ? 6'd16 : 6'd8) : (is_long ? 6'd20 : 6'd12) + extra;
    end else if ((op & OP_HI_MASK) == OP_NOT && sz != OPSZ_BAD && data_alt) begin
      dec_o.cls  = CLS_LOGIC;
      dec_o.kind = LK_EOR;
      dec_o.opa  = '1;
      dec_o.opb  = item_i.ea_operand;
      dec_o.size = sz;
      dec_o.tgt  = dreg_dst ? TGT_DREG : TGT_EA;
      dec_o.treg = dreg_dst ? ereg : 3'd0;
      dec_o.cyc  = dreg_dst ? (is_long ? 6'd6 : 6'd4) : (is_long ? 6'd12 : 6'd8) + extra;
    end else if ((op & OP_EOR_MASK) == OP_EOR && sz != OPSZ_BAD && data_alt) begin
      dec_o.cls  = CLS_LOGIC;
      dec_o.kind = LK_EOR;
      dec_o.opa  = item_i.dreg_operand;
      dec_o.opb  = item_i.ea_operand;
      dec_o.size = sz;
      dec_o.tgt  = dreg_dst ? TGT_DREG : TGT_EA;
      dec_o.treg = dreg_dst ? ereg : 3'd0;
      dec_o.cyc  = dreg_dst ? (is_long ? 6'd8 : 6'd4) : (is_long ? 6'd12 : 6'd8) + extra;
    end else if ((op & OP_LINE_MASK) == OP_AND || (op & OP_LINE_MASK) == OP_OR) begin
      dec_o.kind = ((op & OP_LINE_MASK) == OP_AND) ? LK_AND : LK_OR;
      dec_o.opa  = item_i.ea_operand;
      dec_o.opb  = item_i.dreg_operand;
      if (opm <= 3'd2 && data_src) begin
        dec_o.cls  = CLS_LOGIC;
        dec_o.size = opm[1:0];
        dec_o.tgt  = TGT_DREG;
        dec_o.treg = op[11:9];
        if (opm[1:0] == OPSZ_LONG) begin
          dec_o.cyc = ((dreg_dst || (mode == MODE_EXT && ereg == 3'd4)) ? 6'd8 : 6'd6) +
                      extra;
        end else begin
          dec_o.cyc = 6'd4 + extra;
        end
      end else if (opm >= 3'd4 && opm <= 3'd6 && mem_alt) begin
        dec_o.cls  = CLS_LOGIC;
        dec_o.size = opm[1:0];
        dec_o.tgt  = TGT_EA;
        dec_o.cyc  = ((opm[1:0] == OPSZ_LONG) ? 6'd12 : 6'd8) + extra;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/mli_queue.sv -----
// Two-entry queue of decoded instructions between decode and execute.
// Uses mli_pkg for the decoded item type.
`default_nettype none

module mli_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  mli_pkg::dec_item_t wr_data_i,
  output logic               full_o,
  input  logic               rd_i,
  output logic               valid_o,
  output mli_pkg::dec_item_t rd_data_o
);
  import mli_pkg::*;

  dec_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_wr;
  logic       do_rd;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/mli_back.sv -----
// Execute back of the logic instruction unit: holds the status register,
// carries out one decoded instruction and registers its result. Uses mli_pkg.
`default_nettype none

`include "assert_macros.svh"

module mli_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               dec_valid_i,
  input  mli_pkg::dec_item_t dec_i,
  output logic               dec_take_o,
  output logic               empty_o,
  input  logic               pop_i,
  output mli_pkg::out_item_t result_o
);
  import mli_pkg::*;

  logic [15:0] sr_q, sr_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic [31:0] raw;
  logic [31:0] res;
  logic        msb;
  logic [31:0] sr_logic;

  // A new instruction is taken whenever the result slot is free or drains now.
  assign dec_take_o = dec_valid_i && (!out_valid_q || pop_i);
  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;

  assign raw      = logic_apply(dec_i.kind, dec_i.opa, dec_i.opb);
  assign sr_logic = logic_apply(dec_i.kind, {16'h0000, sr_q}, dec_i.opb);

  always_comb begin
    case (dec_i.size)
      OPSZ_BYTE: begin
        res = {24'h000000, raw[7:0]};
        msb = raw[7];
      end
      OPSZ_WORD: begin
        res = {16'h0000, raw[15:0]};
        msb = raw[15];
      end
      default: begin
        res = raw;
        msb = raw[31];
      end
    endcase
  end

  always_comb begin
    sr_d  = sr_q;
    out_d = '0;
    out_d.outcome = OUTCOME_ILLEGAL;
    unique case (dec_i.cls)
      CLS_LOGIC: begin
        sr_d = {sr_q[15:4], msb, (res == 32'h0), 2'b00} & SR_IMPL_MASK;
        out_d.result_value = res;
        out_d.write_target = dec_i.tgt;
        out_d.target_reg   = dec_i.treg;
        out_d.op_size      = dec_i.size;
        out_d.outcome      = OUTCOME_EXEC;
        out_d.cycle_count  = dec_i.cyc;
      end
      CLS_CCR: begin
        sr_d = sr_logic[15:0] & SR_IMPL_MASK;
        out_d.op_size     = OPSZ_BYTE;
        out_d.outcome     = OUTCOME_EXEC;
        out_d.cycle_count = dec_i.cyc;
      end
      CLS_SR: begin
        out_d.op_size = OPSZ_WORD;
        if (!sr_q[SR_S_BIT]) begin
          // User mode: the write is refused and exception processing is counted.
          out_d.outcome     = OUTCOME_PRIV;
          out_d.cycle_count = 6'd34;
        end else begin
          sr_d = sr_logic[15:0] & SR_IMPL_MASK;
          out_d.outcome          = OUTCOME_EXEC;
          out_d.leave_supervisor = !sr_d[SR_S_BIT];
          out_d.cycle_count      = 6'd20;
        end
      end
      default: begin
        out_d.outcome = OUTCOME_ILLEGAL;
      end
    endcase
    out_d.status_out = sr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= SR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (dec_take_o) begin
        sr_q        <= sr_d;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_take_o) begin
      out_q <= out_d;
    end
  end

  `MLI_ASSERT(a_sr_impl_bits, (sr_q & ~SR_IMPL_MASK) == 16'h0000, "unimplemented SR bit set")
  `MLI_ASSERT(a_status_matches, !out_valid_q || (out_q.status_out == sr_q), "status_out differs from SR")
  `MLI_ASSERT(a_illegal_quiet, !out_valid_q || (out_q.outcome != OUTCOME_ILLEGAL) || ((out_q.result_value == 32'h0) && (out_q.cycle_count == 6'd0) && (out_q.write_target == TGT_NONE)), "illegal opcode result not cleared")
  `MLI_ASSERT_NEXT(a_user_sr_priv, dec_take_o && (dec_i.cls == CLS_SR) && !sr_q[SR_S_BIT], out_q.outcome == OUTCOME_PRIV, "SR write in user mode not refused")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for m68k_logic_instruction_unit. Depends on mli_pkg for
// the payload types and codes; a shadow status register and an instruction predictor
// give the expected results, but for directed rows that carry their own.
module tb;
  import mli_pkg::*;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] opcode;
    out_item_t   want;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  item_i = '0;
  logic      full;
  logic      empty;
  out_item_t result_o;

  logic [15:0] shadow_sr;
  pending_t    pending_results[$];
  dir_row_t    directed_rows[$];
  int          mismatches = 0;
  int          results_seen = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          keep_super = 1'b1;

  m68k_logic_instruction_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("timeout with %0d results still awaited", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_mismatch(string field, logic [15:0] opcode, logic [31:0] got,
                               logic [31:0] want);
    if (mismatches < 100)
      $display("mismatch in %s for opcode %h: got %h, expected %h", field, opcode, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] bool_op(logic_kind_e kind, logic [31:0] a, logic [31:0] b);
    case (kind)
      LK_AND:  return a & b;
      LK_OR:   return a | b;
      default: return a ^ b;
    endcase
  endfunction

  function automatic bit ea_alterable(logic [2:0] mode, logic [2:0] ereg);
    if (mode == MODE_AREG) return 1'b0;
    if (mode == MODE_EXT) return ereg <= 3'd1;
    return 1'b1;
  endfunction

  function automatic bit ea_mem_alterable(logic [2:0] mode, logic [2:0] ereg);
    if (mode == MODE_DREG || mode == MODE_AREG) return 1'b0;
    if (mode == MODE_EXT) return ereg <= 3'd1;
    return 1'b1;
  endfunction

  function automatic bit ea_data_source(logic [2:0] mode, logic [2:0] ereg);
    if (mode == MODE_AREG) return 1'b0;
    if (mode == MODE_EXT) return ereg <= 3'd4;
    return 1'b1;
  endfunction

  // Executes one instruction against the shadow status register.
  function automatic out_item_t predict_logic_op(in_item_t it);
    out_item_t   r;
    logic [15:0] op, sr, hi;
    logic [2:0]  mode, ereg, dnum, opm, treg;
    logic [1:0]  sz, tgt;
    logic [31:0] a, b, mask, msb, res, wide;
    logic [5:0]  extra, cyc;
    logic_kind_e kind;
    logic        hit, islong;
    op = it.opcode;
    sr = shadow_sr;
    hi = op & OP_HI_MASK;
    mode = op[5:3];
    ereg = op[2:0];
    dnum = op[11:9];
    opm = op[8:6];
    sz = op[7:6];
    islong = (sz == OPSZ_LONG);
    extra = {1'b0, it.ea_extra_cycles};
    r = '0;
    r.outcome = OUTCOME_ILLEGAL;
    hit = 1'b0;
    a = '0;
    b = '0;
    kind = LK_AND;
    cyc = '0;
    tgt = TGT_NONE;
    treg = '0;
    if (op == OP_ANDI_CCR || op == OP_ORI_CCR || op == OP_EORI_CCR) begin
      kind = (op == OP_ANDI_CCR) ? LK_AND : (op == OP_ORI_CCR) ? LK_OR : LK_EOR;
      // An AND on the condition codes must leave the system byte untouched.
      b = {16'h0, (kind == LK_AND) ? 8'hFF : 8'h00, it.immediate[7:0]};
      wide = bool_op(kind, {16'h0, sr}, b);
      sr = wide[15:0] & SR_IMPL_MASK;
      r.outcome = OUTCOME_EXEC;
      r.op_size = OPSZ_BYTE;
      r.cycle_count = 6'd20;
    end else if (op == OP_ANDI_SR || op == OP_ORI_SR || op == OP_EORI_SR) begin
      r.op_size = OPSZ_WORD;
      if (!sr[SR_S_BIT]) begin
        r.outcome = OUTCOME_PRIV;
        r.cycle_count = 6'd34;
      end else begin
        kind = (op == OP_ANDI_SR) ? LK_AND : (op == OP_ORI_SR) ? LK_OR : LK_EOR;
        wide = bool_op(kind, {16'h0, sr}, {16'h0, it.immediate[15:0]});
        sr = wide[15:0] & SR_IMPL_MASK;
        r.leave_supervisor = !sr[SR_S_BIT];
        r.outcome = OUTCOME_EXEC;
        r.cycle_count = 6'd20;
      end
    end else begin
      if ((hi == OP_ORI || hi == OP_ANDI || hi == OP_EORI) && sz != OPSZ_BAD &&
          ea_alterable(mode, ereg)) begin
        kind = (hi == OP_ANDI) ? LK_AND : (hi == OP_ORI) ? LK_OR : LK_EOR;
        a = it.immediate;
        b = it.ea_operand;
        hit = 1'b1;
        cyc = (mode == MODE_DREG) ? (islong ? 6'd16 : 6'd8) : (islong ? 6'd20 : 6'd12) + extra;
        tgt = (mode == MODE_DREG) ? TGT_DREG : TGT_EA;
        treg = (mode == MODE_DREG) ? ereg : 3'd0;
      end else if (hi == OP_NOT && sz != OPSZ_BAD && ea_alterable(mode, ereg)) begin
        kind = LK_EOR;
        a = 32'hFFFF_FFFF;
        b = it.ea_operand;
        hit = 1'b1;
        cyc = (mode == MODE_DREG) ? (islong ? 6'd6 : 6'd4) : (islong ? 6'd12 : 6'd8) + extra;
        tgt = (mode == MODE_DREG) ? TGT_DREG : TGT_EA;
        treg = (mode == MODE_DREG) ? ereg : 3'd0;
      end else if ((op & OP_EOR_MASK) == OP_EOR && sz != OPSZ_BAD &&
                   ea_alterable(mode, ereg)) begin
        kind = LK_EOR;
        a = it.dreg_operand;
        b = it.ea_operand;
        hit = 1'b1;
        cyc = (mode == MODE_DREG) ? (islong ? 6'd8 : 6'd4) : (islong ? 6'd12 : 6'd8) + extra;
        tgt = (mode == MODE_DREG) ? TGT_DREG : TGT_EA;
        treg = (mode == MODE_DREG) ? ereg : 3'd0;
      end else if ((op & OP_LINE_MASK) == OP_AND || (op & OP_LINE_MASK) == OP_OR) begin
        kind = ((op & OP_LINE_MASK) == OP_AND) ? LK_AND : LK_OR;
        a = it.ea_operand;
        b = it.dreg_operand;
        sz = opm[1:0];
        if (!opm[2] && opm[1:0] != 2'd3 && ea_data_source(mode, ereg)) begin
          hit = 1'b1;
          tgt = TGT_DREG;
          treg = dnum;
          if (sz == OPSZ_LONG)
            cyc = ((mode == MODE_DREG || (mode == MODE_EXT && ereg == 3'd4)) ? 6'd8 : 6'd6)
                  + extra;
          else
            cyc = 6'd4 + extra;
        end else if (opm[2] && opm[1:0] != 2'd3 && ea_mem_alterable(mode, ereg)) begin
          hit = 1'b1;
          tgt = TGT_EA;
          treg = 3'd0;
          cyc = ((sz == OPSZ_LONG) ? 6'd12 : 6'd8) + extra;
        end
      end
      if (hit) begin
        mask = (sz == OPSZ_BYTE) ? 32'hFF : (sz == OPSZ_WORD) ? 32'hFFFF : 32'hFFFF_FFFF;
        msb = (sz == OPSZ_BYTE) ? 32'h80 : (sz == OPSZ_WORD) ? 32'h8000 : 32'h8000_0000;
        res = bool_op(kind, a, b) & mask;
        // N and Z follow the result, V and C clear, X is kept.
        sr[3:0] = {|(res & msb), res == 32'h0, 2'b00};
        sr = sr & SR_IMPL_MASK;
        r.result_value = res;
        r.write_target = tgt;
        r.target_reg = treg;
        r.op_size = sz;
        r.outcome = OUTCOME_EXEC;
        r.cycle_count = cyc;
      end
    end
    shadow_sr = sr;
    r.status_out = sr;
    return r;
  endfunction

  function automatic logic [31:0] operand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_instr();
    in_item_t   it;
    logic [2:0] mode, ereg, dnum, opm;
    logic [1:0] sz;
    logic [7:0] imm_hi;
    it.immediate = operand_word();
    it.dreg_operand = operand_word();
    it.ea_operand = operand_word();
    it.ea_extra_cycles = 5'($urandom_range(0, 16));
    mode = 3'($urandom_range(0, 7));
    ereg = 3'($urandom);
    dnum = 3'($urandom);
    sz = ($urandom_range(0, 15) == 0) ? OPSZ_BAD : 2'($urandom_range(0, 2));
    opm = ($urandom_range(0, 9) == 0) ? {1'($urandom), 2'd3} :
          {1'($urandom), 2'($urandom_range(0, 2))};
    case ($urandom_range(0, 2))
      0:       imm_hi = OP_ORI[15:8];
      1:       imm_hi = OP_ANDI[15:8];
      default: imm_hi = OP_EORI[15:8];
    endcase
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0:       it.opcode = OP_ANDI_CCR;
          1:       it.opcode = OP_ORI_CCR;
          default: it.opcode = OP_EORI_CCR;
        endcase
      end
      1: begin
        case ($urandom_range(0, 2))
          0:       it.opcode = OP_ANDI_SR;
          1:       it.opcode = OP_ORI_SR;
          default: it.opcode = OP_EORI_SR;
        endcase
      end
      2, 3:    it.opcode = {imm_hi, sz, mode, ereg};
      4:       it.opcode = {OP_NOT[15:8], sz, mode, ereg};
      5:       it.opcode = {OP_EOR[15:12], dnum, OP_EOR[8], sz, mode, ereg};
      6, 7:    it.opcode = {OP_AND[15:12], dnum, opm, mode, ereg};
      8:       it.opcode = {OP_OR[15:12], dnum, opm, mode, ereg};
      default: it.opcode = 16'($urandom);
    endcase
    // Supervisor mode cannot be re-entered without a reset, so SR writes keep S
    // until the closing user-mode stretch.
    if (keep_super) begin
      if (it.opcode == OP_ANDI_SR) it.immediate[SR_S_BIT] = 1'b1;
      if (it.opcode == OP_EORI_SR) it.immediate[SR_S_BIT] = 1'b0;
    end
    return it;
  endfunction

  task automatic add_row(logic [15:0] op, logic [31:0] imm, logic [31:0] dreg,
                         logic [31:0] ea, logic [4:0] extra, logic typed, out_item_t want);
    dir_row_t row;
    row.item = {op, imm, dreg, ea, extra};
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Offers one instruction and waits for its transfer; the expectation is
  // queued at the edge of the transfer.
  task automatic offer(in_item_t it, logic typed, out_item_t want);
    out_item_t predicted;
    pending_t  p;
    item_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    predicted = predict_logic_op(it);
    p.opcode = it.opcode;
    p.want = typed ? want : predicted;
    pending_results.push_back(p);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int tail_start;
    int guard;
    shadow_sr = SR_RESET;
    add_row(OP_ORI_CCR, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h2700, OUTCOME_EXEC, 1'b0, 6'd20});
    add_row(OP_ORI_CCR, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h271F, OUTCOME_EXEC, 1'b0, 6'd20});
    add_row(OP_EORI_CCR, 32'h15, 32'h0, 32'h0, 5'd0, 1'b0, '0);
    add_row(OP_ANDI_CCR, 32'hFFFF_FF00, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h2700, OUTCOME_EXEC, 1'b0, 6'd20});
    add_row({OP_ORI[15:8], OPSZ_BAD, 6'd0}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            5'd16, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h2700, OUTCOME_ILLEGAL, 1'b0, 6'd0});
    add_row({OP_NOT[15:8], OPSZ_WORD, MODE_AREG, 3'd0}, 32'h0, 32'h0, 32'h1234, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h2700, OUTCOME_ILLEGAL, 1'b0, 6'd0});
    add_row(OP_EORI_SR, 32'h0000_8700, 32'h0, 32'h0, 5'd0, 1'b0, '0);
    add_row(OP_ORI_SR, 32'h0000_FFFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'hA71F, OUTCOME_EXEC, 1'b0, 6'd20});
    add_row(OP_ANDI_SR, 32'hFFFF_2700, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'h2700, OUTCOME_EXEC, 1'b0, 6'd20});
    add_row({OP_ANDI[15:8], OPSZ_BYTE, MODE_DREG, 3'd3}, 32'hFFFF_FFFF, 32'h0, 32'h80,
            5'd0, 1'b0, '0);
    add_row({OP_ORI[15:8], OPSZ_WORD, 3'd2, 3'd0}, 32'h0, 32'h0, 32'h0, 5'd16, 1'b0, '0);
    add_row({OP_EORI[15:8], OPSZ_LONG, MODE_DREG, 3'd0}, 32'hFFFF_FFFF, 32'h0, 32'h0,
            5'd0, 1'b0, '0);
    add_row({OP_EORI[15:8], OPSZ_BYTE, MODE_EXT, 3'd1}, 32'h5A, 32'h0, 32'hA5, 5'd16,
            1'b0, '0);
    add_row({OP_NOT[15:8], OPSZ_BYTE, MODE_DREG, 3'd7}, 32'h0, 32'h0, 32'hFF, 5'd0, 1'b0, '0);
    add_row({OP_NOT[15:8], OPSZ_LONG, 3'd2, 3'd1}, 32'h0, 32'h0, 32'h7FFF_FFFF, 5'd16,
            1'b0, '0);
    add_row({OP_NOT[15:8], OPSZ_WORD, MODE_DREG, 3'd0}, 32'h0, 32'h0, 32'h0, 5'd0, 1'b0, '0);
    add_row({OP_EOR[15:12], 3'd0, OP_EOR[8], OPSZ_WORD, MODE_DREG, 3'd5}, 32'h0,
            32'hFFFF_00FF, 32'h00FF_00FF, 5'd0, 1'b0, '0);
    add_row({OP_EOR[15:12], 3'd7, OP_EOR[8], OPSZ_LONG, 3'd3, 3'd7}, 32'h0,
            32'h8000_0001, 32'h0000_0001, 5'd16, 1'b0, '0);
    add_row({OP_AND[15:12], 3'd2, 3'd2, MODE_EXT, 3'd4}, 32'h0, 32'hFFFF_FFFF,
            32'hF0F0_F0F0, 5'd0, 1'b0, '0);
    add_row({OP_OR[15:12], 3'd1, 3'd4, 3'd3, 3'd0}, 32'h0, 32'h0, 32'h0, 5'd16, 1'b0, '0);
    add_row({OP_AND[15:12], 3'd4, 3'd1, MODE_EXT, 3'd2}, 32'h0, 32'h8000, 32'hFFFF,
            5'd4, 1'b0, '0);
    add_row({OP_OR[15:12], 3'd0, 3'd2, MODE_AREG, 3'd3}, 32'h0, 32'h1, 32'h2, 5'd0, 1'b0, '0);
    add_row({OP_AND[15:12], 3'd0, 3'd4, MODE_DREG, 3'd1}, 32'h0, 32'h1, 32'h1, 5'd0,
            1'b0, '0);
    add_row(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 1'b0, '0);
    add_row({OP_ORI[15:8], OPSZ_LONG, MODE_EXT, 3'd4}, 32'h1, 32'h0, 32'h0, 5'd0, 1'b0, '0);
    tail_start = directed_rows.size();
    // User-mode stretch: leaving supervisor mode, then refused SR writes and a CCR write.
    add_row(OP_ANDI_SR, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'h0000, OUTCOME_EXEC, 1'b1, 6'd20});
    add_row(OP_ORI_SR, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'h0000, OUTCOME_PRIV, 1'b0, 6'd34});
    add_row(OP_EORI_SR, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'h0000, OUTCOME_PRIV, 1'b0, 6'd34});
    add_row(OP_ANDI_SR, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_WORD, 16'h0000, OUTCOME_PRIV, 1'b0, 6'd34});
    add_row(OP_ORI_CCR, 32'hFF, 32'h0, 32'h0, 5'd0, 1'b1,
            {32'd0, TGT_NONE, 3'd0, OPSZ_BYTE, 16'h001F, OUTCOME_EXEC, 1'b0, 6'd20});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < tail_start; i++)
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      offer(random_instr(), 1'b0, '0);
    end
    keep_super = 1'b0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = tail_start; i < directed_rows.size(); i++)
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    for (int n = 0; n < 150; n++)
      offer(random_instr(), 1'b0, '0);
    push <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    int        stall_left;
    bit        long_hold_done;
    pending_t  p;
    out_item_t got;
    stall_left = 0;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = result_o;
        results_seen++;
        if (pending_results.size() == 0) begin
          flag_mismatch("transfer with nothing expected", 16'h0, got.result_value, 32'h0);
        end else begin
          p = pending_results.pop_front();
          if (got.result_value !== p.want.result_value)
            flag_mismatch("result_value", p.opcode, got.result_value, p.want.result_value);
          if (got.write_target !== p.want.write_target)
            flag_mismatch("write_target", p.opcode, got.write_target, p.want.write_target);
          if (got.target_reg !== p.want.target_reg)
            flag_mismatch("target_reg", p.opcode, got.target_reg, p.want.target_reg);
          if (got.op_size !== p.want.op_size)
            flag_mismatch("op_size", p.opcode, got.op_size, p.want.op_size);
          if (got.status_out !== p.want.status_out)
            flag_mismatch("status_out", p.opcode, got.status_out, p.want.status_out);
          if (got.outcome !== p.want.outcome)
            flag_mismatch("outcome", p.opcode, got.outcome, p.want.outcome);
          if (got.leave_supervisor !== p.want.leave_supervisor)
            flag_mismatch("leave_supervisor", p.opcode, got.leave_supervisor,
                          p.want.leave_supervisor);
          if (got.cycle_count !== p.want.cycle_count)
            flag_mismatch("cycle_count", p.opcode, got.cycle_count, p.want.cycle_count);
        end
      end
      // One long hold-off lets the queue fill so that full must rise.
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        stall_left = 80;
      end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

endmodule
